>>> rtl/lookahead_peak_limiter_macros.svh
// Assertion macros shared by the limiter RTL.
`ifndef LOOKAHEAD_PEAK_LIMITER_MACROS_SVH
`define LOOKAHEAD_PEAK_LIMITER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LPL_ASSERT_HOLDS(label, ck, rn, ante, cons) \
label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
	else $error("lookahead_peak_limiter: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define LPL_ASSERT_NEXT(label, ck, rn, ante, cons) \
label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
	else $error("lookahead_peak_limiter: next-cycle check failed");

`endif

>>> rtl/lpl_pkg.sv
package lpl_pkg;

	localparam int CFG_INDEX_BITS = 2;
	localparam int LOOKAHEAD_BITS = 8;

	localparam logic [CFG_INDEX_BITS-1:0] REG_CEILING   = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_RELEASE   = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_LOOKAHEAD = 2'd2;

	localparam logic [31:0] CEILING_RESET = 32'd7476239;
	localparam logic [31:0] RELEASE_RESET = 32'd16770227;
	localparam logic [LOOKAHEAD_BITS-1:0] LOOKAHEAD_RESET = 8'd96;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_MUL,
		S_GAIN,
		S_APPLY,
		S_EMIT
	} lpl_state_t;

	typedef struct packed {
		logic write;
		logic read;
	} lpl_mem_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} lpl_div_stat_t;

endpackage

>>> rtl/lpl_in_if.sv
interface lpl_in_if #(
	parameter int SAMPLE_BITS = 24
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_in;
	logic                          block_end_in;

	modport source(output valid, output sample_in, output block_end_in, input ready);
	modport sink(input valid, input sample_in, input block_end_in, output ready);
endinterface

>>> rtl/lpl_out_if.sv
interface lpl_out_if #(
	parameter int SAMPLE_BITS = 24
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_out;
	logic        [SAMPLE_BITS-1:0] gain_applied;
	logic                          block_end_out;

	modport source(output valid, output sample_out, output gain_applied,
		output block_end_out, input ready);
	modport sink(input valid, input sample_out, input gain_applied,
		input block_end_out, output ready);
endinterface

>>> rtl/lookahead_peak_limiter.sv
// Channel   Role    Handshake      Payload
// audio     sink    valid/ready    sample_in, block_end_in
// limited   source  valid/ready    sample_out, gain_applied, block_end_out
// cfg       write   cfg_write      cfg_index, cfg_data
//
// A result is loaded into the output register after its request passes S_MUL, S_GAIN,
// S_APPLY and S_EMIT; a sample that exceeds the ceiling first waits in S_DIV for the
// serial divider. The next request is taken in S_IDLE once S_EMIT has loaded the result.
// The delay memory is not cleared: a fill mark makes unwritten entries read as zero.
// Reset restores the register defaults, unity gain and an empty delay line.
// A result waits in the output register; a new request is taken meanwhile.
`include "lookahead_peak_limiter_macros.svh"

module lookahead_peak_limiter #(
	parameter int DELAY_DEPTH = 256,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	lpl_in_if.sink                               audio,
	lpl_out_if.source                            limited,
	input  logic                                 cfg_write,
	input  logic [lpl_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [SAMPLE_BITS-1:0]               cfg_data
);
	import lpl_pkg::*;

	localparam int SB = SAMPLE_BITS;
	localparam logic [SB-1:0] UNITY = {1'b1, {(SB-1){1'b0}}};
	localparam logic [SB-2:0] CEIL_RST = CEILING_RESET[SB-2:0];
	localparam logic [SB-1:0] REL_RST = RELEASE_RESET[SB-1:0];

	lpl_state_t state_q, state_d;

	logic [SB-2:0]             ceiling_q;
	logic [SB-1:0]             release_q;
	logic [LOOKAHEAD_BITS-1:0] lookahead_q;

	logic [SB-1:0]        gain_q;
	logic                 limit_q;
	logic                 block_end_q;
	logic [SB-1:0]        mag_q;
	logic [2*SB-1:0]      rel_prod_s1;
	logic signed [2*SB:0] out_prod_s1;

	logic signed [SB-1:0] out_sample_q;
	logic [SB-1:0]        out_gain_q;
	logic                 out_end_q;
	logic                 out_valid_q;

	logic          accept;
	logic          in_ready;
	logic          div_start;
	logic          emit_load;
	logic [SB-1:0] in_mag;
	logic          in_limit;
	lpl_mem_ctl_t  mem_ctl;
	lpl_div_stat_t div_stat;
	logic [SB-2:0] quotient;
	logic [SB-1:0] delayed;
	logic [SB-1:0] target;
	logic [SB:0]   rel_inv;
	logic [2*SB-1:0] rel_acc;
	logic [SB-1:0] rel_gain;

	assign accept = audio.valid && in_ready;
	assign in_mag = audio.sample_in[SB-1] ? SB'(~audio.sample_in + 1'b1) : audio.sample_in;
	assign in_limit = in_mag > {1'b0, ceiling_q};

	lpl_delay_line #(
		.DELAY_DEPTH(DELAY_DEPTH),
		.SAMPLE_BITS(SB)
	) u_delay (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (mem_ctl),
		.wr_data  (audio.sample_in),
		.lookahead(lookahead_q),
		.rd_data  (delayed)
	);

	lpl_divider #(
		.SAMPLE_BITS(SB)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.ceiling  (ceiling_q),
		.magnitude(in_mag),
		.quotient (quotient),
		.stat     (div_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ceiling_q   <= CEIL_RST;
			release_q   <= REL_RST;
			lookahead_q <= LOOKAHEAD_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_CEILING: begin
					ceiling_q <= cfg_data[SB-2:0];
				end
				REG_RELEASE: begin
					release_q <= cfg_data;
				end
				REG_LOOKAHEAD: begin
					lookahead_q <= cfg_data[LOOKAHEAD_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = in_limit ? S_DIV : S_MUL;
				end
			end
			S_DIV: begin
				if (div_stat.done) begin
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				state_d = S_GAIN;
			end
			S_GAIN: begin
				state_d = S_APPLY;
			end
			S_APPLY: begin
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (emit_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready      = 1'b0;
		div_start     = 1'b0;
		emit_load     = 1'b0;
		mem_ctl.write = 1'b0;
		mem_ctl.read  = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready      = 1'b1;
				mem_ctl.write = audio.valid;
				div_start     = audio.valid && in_limit;
			end
			S_MUL: begin
				mem_ctl.read = 1'b1;
			end
			S_EMIT: begin
				emit_load = !out_valid_q || limited.ready;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			gain_q      <= UNITY;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_GAIN) begin
				gain_q <= (target < gain_q) ? target : rel_gain;
			end
			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (limited.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign target = limit_q ? {1'b0, quotient} : UNITY;
	assign rel_inv = {1'b1, {SB{1'b0}}} - {1'b0, release_q};
	assign rel_acc = rel_prod_s1 + {rel_inv, {(SB-1){1'b0}}};
	assign rel_gain = rel_acc[2*SB-1:SB];

	always_ff @(posedge clk) begin
		if (accept) begin
			mag_q       <= in_mag;
			limit_q     <= in_limit;
			block_end_q <= audio.block_end_in;
		end
		if (state_q == S_MUL) begin
			rel_prod_s1 <= release_q * gain_q;
		end
		if (state_q == S_APPLY) begin
			out_prod_s1 <= $signed(delayed) * $signed({1'b0, gain_q});
		end
		if (emit_load) begin
			out_sample_q <= out_prod_s1[2*SB-2:SB-1];
			out_gain_q   <= gain_q;
			out_end_q    <= block_end_q;
		end
	end

	assign audio.ready           = in_ready;
	assign limited.valid         = out_valid_q;
	assign limited.sample_out    = out_sample_q;
	assign limited.gain_applied  = out_gain_q;
	assign limited.block_end_out = out_end_q;

	`LPL_ASSERT_NEXT(a_accept_busy, clk, arst_n, audio.valid && audio.ready, state_q != S_IDLE)
	`LPL_ASSERT_HOLDS(a_gain_bound, clk, arst_n, limited.valid, limited.gain_applied <= UNITY)
	`LPL_ASSERT_HOLDS(a_div_live, clk, arst_n, state_q == S_DIV, div_stat.busy && mag_q != '0)
	`LPL_ASSERT_NEXT(a_emit_hold, clk, arst_n,
		state_q == S_EMIT && limited.valid && !limited.ready, state_q == S_EMIT)

endmodule

>>> rtl/lpl_delay_line.sv
module lpl_delay_line #(
	parameter int DELAY_DEPTH = 256,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  lpl_pkg::lpl_mem_ctl_t                ctl,
	input  logic [SAMPLE_BITS-1:0]               wr_data,
	input  logic [lpl_pkg::LOOKAHEAD_BITS-1:0]   lookahead,
	output logic [SAMPLE_BITS-1:0]               rd_data
);
	import lpl_pkg::*;

	localparam int AW = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
	localparam int LOOK_ENTRIES = 1 << LOOKAHEAD_BITS;

	logic [SAMPLE_BITS-1:0] mem_q [DELAY_DEPTH];
	logic [SAMPLE_BITS-1:0] rd_raw_q;
	logic                   rd_ok_q;
	logic [AW-1:0]          wp_q;
	logic [AW-1:0]          rp_q;
	logic                   filled_q;
	logic [AW-1:0]          look_mod_tbl [LOOK_ENTRIES];
	logic [AW-1:0]          look_mod;
	logic [AW:0]            rp_sum;
	logic [AW-1:0]          rp_next;

	for (genvar g = 0; g < LOOK_ENTRIES; g++) begin : g_mod
		assign look_mod_tbl[g] = AW'(g % DELAY_DEPTH);
	end

	assign look_mod = look_mod_tbl[lookahead];
	assign rp_sum = {1'b0, wp_q} + (AW+1)'(DELAY_DEPTH) - {1'b0, look_mod};
	assign rp_next = (rp_sum >= (AW+1)'(DELAY_DEPTH)) ?
		AW'(rp_sum - (AW+1)'(DELAY_DEPTH)) : rp_sum[AW-1:0];

	always_ff @(posedge clk) begin
		if (ctl.write) begin
			mem_q[wp_q] <= wr_data;
		end
		if (ctl.read) begin
			rd_raw_q <= mem_q[rp_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q     <= '0;
			rp_q     <= '0;
			filled_q <= 1'b0;
			rd_ok_q  <= 1'b0;
		end else begin
			if (ctl.write) begin
				rp_q <= rp_next;
			end
			if (ctl.read) begin
				// Entries not yet reached by the write head still read as zero.
				rd_ok_q <= filled_q || (rp_q <= wp_q);
				if (wp_q == AW'(DELAY_DEPTH - 1)) begin
					wp_q     <= '0;
					filled_q <= 1'b1;
				end else begin
					wp_q <= wp_q + 1'b1;
				end
			end
		end
	end

	assign rd_data = rd_ok_q ? rd_raw_q : '0;

endmodule

>>> rtl/lpl_divider.sv
module lpl_divider #(
	parameter int SAMPLE_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [SAMPLE_BITS-2:0]        ceiling,
	input  logic [SAMPLE_BITS-1:0]        magnitude,
	output logic [SAMPLE_BITS-2:0]        quotient,
	output lpl_pkg::lpl_div_stat_t        stat
);
	import lpl_pkg::*;

	localparam int STEPS = SAMPLE_BITS - 1;
	localparam int CW = $clog2(SAMPLE_BITS);

	logic [CW-1:0]          cnt_q;
	logic [SAMPLE_BITS-1:0] rem_q;
	logic [SAMPLE_BITS-1:0] div_q;
	logic [SAMPLE_BITS-2:0] quo_q;
	logic [SAMPLE_BITS:0]   shifted;
	logic                   fits;

	// The remainder stays below the divisor, so one doubling fits in one extra bit.
	assign shifted = {rem_q, 1'b0};
	assign fits = shifted >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(STEPS);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, ceiling};
			div_q <= magnitude;
			quo_q <= '0;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? SAMPLE_BITS'(shifted - {1'b0, div_q}) : shifted[SAMPLE_BITS-1:0];
			quo_q <= {quo_q[SAMPLE_BITS-3:0], fits};
		end
	end

	assign quotient = quo_q;
	assign stat.busy = cnt_q != '0;
	assign stat.done = cnt_q == CW'(1);

endmodule
